@@ rtl/tgp_pkg.sv @@
// Shared constants, font glyph store and types for the text glyph pixel generator.
package tgp_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int GLYPH_COLUMNS = 5;
    localparam int GLYPH_ROWS    = 8;
    localparam int GLYPH_BITS    = GLYPH_COLUMNS * GLYPH_ROWS;
    localparam int GLYPH_COUNT   = 59;
    localparam int POS_W         = $clog2(GLYPH_BITS);
    localparam int ROW_W         = $clog2(GLYPH_ROWS);
    localparam int CFG_INDEX_W   = 2;

    localparam logic [7:0] FIRST_CODE  = 8'd32;
    localparam logic [7:0] LAST_CODE   = 8'd90;
    localparam logic [7:0] ADVANCE_X   = 8'd6;
    localparam logic [7:0] ADVANCE_Y   = 8'd8;
    localparam logic [7:0] WRAP_LIMIT  = 8'(SCREEN_WIDTH - 6);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(GLYPH_BITS - 1);

    localparam logic [CFG_INDEX_W-1:0] REG_FG_COLOR = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_BG_COLOR = CFG_INDEX_W'(1);

    // Each entry packs five columns, column 0 in the low byte, row 0 in bit 0 of a column.
    localparam logic [GLYPH_BITS-1:0] FONT_GLYPHS [0:GLYPH_COUNT-1] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h122A7F2A24, 40'h6264081323, 40'h5022554936, 40'h0000030500,
        40'h0041221C00, 40'h001C224100, 40'h14083E0814, 40'h08083E0808,
        40'h0000305000, 40'h0808080808, 40'h0000606000, 40'h0204081020,
        40'h3E4549513E, 40'h00407F4200, 40'h4649516142, 40'h314B454121,
        40'h107F121418, 40'h3945454527, 40'h3049494A3C, 40'h0305097101,
        40'h3649494936, 40'h1E29494906, 40'h0000363600, 40'h0000365600,
        40'h0041221408, 40'h1414141414, 40'h0814224100, 40'h0609510102,
        40'h3E41794932, 40'h7E1111117E, 40'h364949497F, 40'h224141413E,
        40'h1C2241417F, 40'h414949497F, 40'h010909097F, 40'h7A4949413E,
        40'h7F0808087F, 40'h00417F4100, 40'h013F414020, 40'h004428107F,
        40'h404040407F, 40'h7F020C027F, 40'h7F1008047F, 40'h3E4141413E,
        40'h060909097F, 40'h5E2151413E, 40'h462919097F, 40'h3249494926,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3C4038403F,
        40'h6314081463, 40'h0708700807, 40'h4345495161
    };

    typedef struct packed {
        logic                  start;
        logic [GLYPH_BITS-1:0] glyph;
        logic [7:0]            base_x;
        logic [7:0]            base_y;
    } load_t;

    function automatic logic [GLYPH_BITS-1:0] glyph_of(input logic [7:0] code);
        logic [7:0] idx;
        idx = 8'd0;
        if (code >= FIRST_CODE && code <= LAST_CODE)
        begin
            idx = code - FIRST_CODE;
        end
        return FONT_GLYPHS[idx[5:0]];
    endfunction

endpackage

@@ rtl/tgp_walker.sv @@
// Glyph walker: steps through the 40 glyph bits and emits one pixel beat per set or drawn bit.
module tgp_walker (
    input  logic              clk,
    input  logic              rst_n,
    input  tgp_pkg::load_t    load,
    input  logic [15:0]       fg_color,
    input  logic [15:0]       bg_color,
    output logic              busy,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        pixel_x,
    output logic [7:0]        pixel_y,
    output logic [15:0]       pixel_color,
    output logic              last_pixel
);

    typedef enum logic {IDLE, RUN} state_t;

    state_t                              state_reg;
    logic [tgp_pkg::POS_W-1:0]           pos_reg;
    logic [tgp_pkg::GLYPH_BITS-1:0]      bits_reg;
    logic [7:0]                          base_x_reg;
    logic [7:0]                          base_y_reg;
    logic                                out_valid_reg;
    logic [7:0]                          pixel_x_reg;
    logic [7:0]                          pixel_y_reg;
    logic [15:0]                         pixel_color_reg;
    logic                                last_reg;

    logic step;
    logic colors_differ;
    logic emit;
    logic is_last;

    assign colors_differ = (fg_color != bg_color);
    assign step          = (state_reg == RUN) && (!out_valid_reg || !out_stall);
    assign emit          = bits_reg[0] || colors_differ;
    assign is_last       = colors_differ ? (pos_reg == tgp_pkg::LAST_POS)
                                         : (bits_reg[tgp_pkg::GLYPH_BITS-1:1] == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= IDLE;
            pos_reg         <= '0;
            bits_reg        <= '0;
            base_x_reg      <= '0;
            base_y_reg      <= '0;
            out_valid_reg   <= 1'b0;
            pixel_x_reg     <= '0;
            pixel_y_reg     <= '0;
            pixel_color_reg <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            case (state_reg)
                IDLE:
                begin
                    if (out_valid_reg && !out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    if (load.start)
                    begin
                        state_reg  <= RUN;
                        pos_reg    <= '0;
                        bits_reg   <= load.glyph;
                        base_x_reg <= load.base_x;
                        base_y_reg <= load.base_y;
                    end
                end
                RUN:
                begin
                    if (step)
                    begin
                        out_valid_reg <= emit;
                        if (emit)
                        begin
                            pixel_x_reg     <= base_x_reg
                                               + 8'(pos_reg >> tgp_pkg::ROW_W);
                            pixel_y_reg     <= base_y_reg
                                               + 8'(pos_reg[tgp_pkg::ROW_W-1:0]);
                            pixel_color_reg <= bits_reg[0] ? fg_color : bg_color;
                            last_reg        <= is_last;
                        end
                        bits_reg <= bits_reg >> 1;
                        pos_reg  <= pos_reg + 1'b1;
                        if (pos_reg == tgp_pkg::LAST_POS)
                        begin
                            state_reg <= IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign busy        = (state_reg == RUN);
    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_color = pixel_color_reg;
    assign last_pixel  = last_reg;

    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load.start |-> state_reg == IDLE)
        else $error("character loaded while a walk is in progress");

    a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
        step && pos_reg == tgp_pkg::LAST_POS |=> state_reg == IDLE)
        else $error("walk did not end after the final glyph bit");

    a_beat_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == RUN))
        else $error("pixel beat appeared without an active walk");

    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !last_reg |-> state_reg == RUN)
        else $error("non-final pixel beat with no walk left to finish it");

endmodule

@@ rtl/text_glyph_pixel_generator.sv @@
// Top level of the text glyph pixel generator: configuration, cursor and glyph walker.
//
// Input channel (in_valid / in_stall) carries one character per beat, with an
// optional string_start flag that first loads the cursor from start_x/start_y.
// Output channel (out_valid / out_stall) carries one pixel write per beat:
// coordinates, RGB565 color and a last_pixel flag on the final pixel of a
// character. Set glyph bits use fg_color; clear bits use bg_color and are skipped
// when both colors are equal, so a blank glyph may produce no beats at all.
// The glyph walker visits the 40 bits of a 5x8 glyph one per cycle, pausing while
// a stalled pixel beat is held. The first pixel is registered only after the walker
// has entered its RUN state for the accepted character. in_stall is high while the
// walker is busy; the next character is accepted in the cycle after the walk ends.
// A stall on the output holds the current pixel beat and pauses the walk.
// Colors must be written by the user through cfg_write/cfg_index/cfg_data only while
// the block is idle; the block itself does not enforce this.
// Reset sets the cursor to zero, fg_color to white and bg_color to black.
module text_glyph_pixel_generator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [tgp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                     cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            string_start,
    input  logic [7:0]                      start_x,
    input  logic [7:0]                      start_y,
    input  logic [7:0]                      char_code,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      pixel_x,
    output logic [7:0]                      pixel_y,
    output logic [15:0]                     pixel_color,
    output logic                            last_pixel
);

    logic [15:0] fg_color_reg;
    logic [15:0] bg_color_reg;
    logic [7:0]  cursor_x_reg;
    logic [7:0]  cursor_y_reg;
    logic [7:0]  cursor_x_next;
    logic [7:0]  cursor_y_next;

    logic           busy;
    logic           accept;
    logic [7:0]     cur_x;
    logic [7:0]     cur_y;
    logic [7:0]     adv_x;
    tgp_pkg::load_t load;

    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    always_comb
    begin
        cur_x = string_start ? start_x : cursor_x_reg;
        cur_y = string_start ? start_y : cursor_y_reg;
        adv_x = cur_x + tgp_pkg::ADVANCE_X;
        if (adv_x > tgp_pkg::WRAP_LIMIT)
        begin
            cursor_x_next = 8'd0;
            cursor_y_next = cur_y + tgp_pkg::ADVANCE_Y;
        end
        else
        begin
            cursor_x_next = adv_x;
            cursor_y_next = cur_y;
        end
        load.start  = accept;
        load.glyph  = tgp_pkg::glyph_of(char_code);
        load.base_x = cur_x;
        load.base_y = cur_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_color_reg <= 16'hFFFF;
            bg_color_reg <= 16'h0000;
            cursor_x_reg <= 8'd0;
            cursor_y_reg <= 8'd0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    tgp_pkg::REG_FG_COLOR: fg_color_reg <= cfg_data;
                    tgp_pkg::REG_BG_COLOR: bg_color_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                cursor_x_reg <= cursor_x_next;
                cursor_y_reg <= cursor_y_next;
            end
        end
    end

    tgp_walker u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .fg_color    (fg_color_reg),
        .bg_color    (bg_color_reg),
        .busy        (busy),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last_pixel  (last_pixel)
    );

endmodule

@@ test/tb.sv @@
// Self-checking bench for the text glyph pixel generator: character beats in, pixel beats checked.
`timescale 1ns / 1ps

module tb;

    localparam int         SCREEN_W     = 128;
    localparam int         GLYPH_W      = 5;
    localparam int         GLYPH_H      = 8;
    localparam int         FONT_BYTES   = 295;
    localparam logic [7:0] FIRST_GLYPH  = 8'd32;
    localparam logic [7:0] LAST_GLYPH   = 8'd90;
    localparam logic [7:0] X_ADVANCE    = 8'd6;
    localparam logic [7:0] Y_ADVANCE    = 8'd8;
    localparam logic [7:0] WRAP_X       = 8'(SCREEN_W - 6);
    localparam int         LATENCY_GAP  = 60;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         LIMIT_CYCLES = 200000;

    localparam logic [tgp_pkg::CFG_INDEX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [tgp_pkg::CFG_INDEX_W-1:0] REG_UNUSED_B = 2'd3;

    localparam logic [FONT_BYTES*8-1:0] FONT_STRIP = {
        8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h5F,8'h00,8'h00,
        8'h00,8'h07,8'h00,8'h07,8'h00, 8'h14,8'h7F,8'h14,8'h7F,8'h14,
        8'h24,8'h2A,8'h7F,8'h2A,8'h12, 8'h23,8'h13,8'h08,8'h64,8'h62,
        8'h36,8'h49,8'h55,8'h22,8'h50, 8'h00,8'h05,8'h03,8'h00,8'h00,
        8'h00,8'h1C,8'h22,8'h41,8'h00, 8'h00,8'h41,8'h22,8'h1C,8'h00,
        8'h14,8'h08,8'h3E,8'h08,8'h14, 8'h08,8'h08,8'h3E,8'h08,8'h08,
        8'h00,8'h50,8'h30,8'h00,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08,
        8'h00,8'h60,8'h60,8'h00,8'h00, 8'h20,8'h10,8'h08,8'h04,8'h02,
        8'h3E,8'h51,8'h49,8'h45,8'h3E, 8'h00,8'h42,8'h7F,8'h40,8'h00,
        8'h42,8'h61,8'h51,8'h49,8'h46, 8'h21,8'h41,8'h45,8'h4B,8'h31,
        8'h18,8'h14,8'h12,8'h7F,8'h10, 8'h27,8'h45,8'h45,8'h45,8'h39,
        8'h3C,8'h4A,8'h49,8'h49,8'h30, 8'h01,8'h71,8'h09,8'h05,8'h03,
        8'h36,8'h49,8'h49,8'h49,8'h36, 8'h06,8'h49,8'h49,8'h29,8'h1E,
        8'h00,8'h36,8'h36,8'h00,8'h00, 8'h00,8'h56,8'h36,8'h00,8'h00,
        8'h08,8'h14,8'h22,8'h41,8'h00, 8'h14,8'h14,8'h14,8'h14,8'h14,
        8'h00,8'h41,8'h22,8'h14,8'h08, 8'h02,8'h01,8'h51,8'h09,8'h06,
        8'h32,8'h49,8'h79,8'h41,8'h3E, 8'h7E,8'h11,8'h11,8'h11,8'h7E,
        8'h7F,8'h49,8'h49,8'h49,8'h36, 8'h3E,8'h41,8'h41,8'h41,8'h22,
        8'h7F,8'h41,8'h41,8'h22,8'h1C, 8'h7F,8'h49,8'h49,8'h49,8'h41,
        8'h7F,8'h09,8'h09,8'h09,8'h01, 8'h3E,8'h41,8'h49,8'h49,8'h7A,
        8'h7F,8'h08,8'h08,8'h08,8'h7F, 8'h00,8'h41,8'h7F,8'h41,8'h00,
        8'h20,8'h40,8'h41,8'h3F,8'h01, 8'h7F,8'h10,8'h28,8'h44,8'h00,
        8'h7F,8'h40,8'h40,8'h40,8'h40, 8'h7F,8'h02,8'h0C,8'h02,8'h7F,
        8'h7F,8'h04,8'h08,8'h10,8'h7F, 8'h3E,8'h41,8'h41,8'h41,8'h3E,
        8'h7F,8'h09,8'h09,8'h09,8'h06, 8'h3E,8'h41,8'h51,8'h21,8'h5E,
        8'h7F,8'h09,8'h19,8'h29,8'h46, 8'h26,8'h49,8'h49,8'h49,8'h32,
        8'h01,8'h01,8'h7F,8'h01,8'h01, 8'h3F,8'h40,8'h40,8'h40,8'h3F,
        8'h1F,8'h20,8'h40,8'h20,8'h1F, 8'h3F,8'h40,8'h38,8'h40,8'h3C,
        8'h63,8'h14,8'h08,8'h14,8'h63, 8'h07,8'h08,8'h70,8'h08,8'h07,
        8'h61,8'h51,8'h49,8'h45,8'h43
    };

    typedef struct {
        logic [7:0]  x;
        logic [7:0]  y;
        logic [15:0] color;
        logic        last;
    } pixel_t;

    typedef struct {
        logic       load;
        logic [7:0] sx;
        logic [7:0] sy;
        logic [7:0] code;
        logic       drain;
    } char_beat_t;

    logic                            clk          = 1'b0;
    logic                            rst_n        = 1'b0;
    logic                            cfg_write    = 1'b0;
    logic [tgp_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [15:0]                     cfg_data     = '0;
    logic                            in_valid     = 1'b0;
    logic                            in_stall;
    logic                            string_start = 1'b0;
    logic [7:0]                      start_x      = '0;
    logic [7:0]                      start_y      = '0;
    logic [7:0]                      char_code    = '0;
    logic                            out_valid;
    logic                            out_stall    = 1'b0;
    logic [7:0]                      pixel_x;
    logic [7:0]                      pixel_y;
    logic [15:0]                     pixel_color;
    logic                            last_pixel;

    char_beat_t char_queue[$];
    pixel_t     expected_pixels[$];
    char_beat_t next_char;
    pixel_t     want;
    logic       offer;

    logic [15:0] fg_model = 16'hFFFF;
    logic [15:0] bg_model = 16'h0000;
    logic [7:0]  cursor_x = 8'd0;
    logic [7:0]  cursor_y = 8'd0;

    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_request  = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int mismatches    = 0;
    int cycle_count   = 0;
    logic [15:0] shade;

    text_glyph_pixel_generator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .string_start (string_start),
        .start_x      (start_x),
        .start_y      (start_y),
        .char_code    (char_code),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_color  (pixel_color),
        .last_pixel   (last_pixel)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic predict_pixels(input logic load, input logic [7:0] sx,
                                  input logic [7:0] sy, input logic [7:0] code);
        logic [7:0] glyph_code;
        logic [7:0] column_bits;
        pixel_t     held;
        logic       have_held;
        int         base;
        if (load)
        begin
            cursor_x = sx;
            cursor_y = sy;
        end
        glyph_code = code;
        if (code < FIRST_GLYPH || code > LAST_GLYPH)
        begin
            glyph_code = FIRST_GLYPH;
        end
        base = (int'(glyph_code) - int'(FIRST_GLYPH)) * GLYPH_W;
        have_held = 1'b0;
        for (int col = 0; col < GLYPH_W; col++)
        begin
            column_bits = FONT_STRIP[(FONT_BYTES - 1 - (base + col)) * 8 +: 8];
            for (int row = 0; row < GLYPH_H; row++)
            begin
                if (column_bits[row] || bg_model != fg_model)
                begin
                    if (have_held)
                    begin
                        expected_pixels.push_back(held);
                    end
                    held.x     = cursor_x + 8'(col);
                    held.y     = cursor_y + 8'(row);
                    held.color = column_bits[row] ? fg_model : bg_model;
                    held.last  = 1'b0;
                    have_held  = 1'b1;
                end
            end
        end
        if (have_held)
        begin
            held.last = 1'b1;
            expected_pixels.push_back(held);
        end
        cursor_x = cursor_x + X_ADVANCE;
        if (cursor_x > WRAP_X)
        begin
            cursor_x = 8'd0;
            cursor_y = cursor_y + Y_ADVANCE;
        end
    endtask

    task automatic add_char(input logic load, input logic [7:0] sx, input logic [7:0] sy,
                            input logic [7:0] code, input logic drain);
        char_beat_t beat;
        beat.load  = load;
        beat.sx    = sx;
        beat.sy    = sy;
        beat.code  = code;
        beat.drain = drain;
        char_queue.push_back(beat);
    endtask

    // Strings start with a cursor load; a few stray loads and off-font codes are mixed in.
    task automatic queue_text(input int count);
        int         left;
        int         len;
        logic [7:0] sx;
        logic [7:0] code;
        left = count;
        while (left > 0)
        begin
            len = $urandom_range(8, 1);
            for (int k = 0; k < len && left > 0; k++)
            begin
                sx   = ($urandom_range(3) != 0) ? 8'($urandom_range(127)) : 8'($urandom);
                code = ($urandom_range(9) < 8) ? 8'($urandom_range(90, 32)) : 8'($urandom);
                add_char((k == 0) || ($urandom_range(15) == 0), sx, 8'($urandom), code,
                         (k == 0) && ($urandom_range(9) == 0));
                left = left - 1;
            end
        end
    endtask

    task automatic write_reg(input logic [tgp_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [15:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == tgp_pkg::REG_FG_COLOR)
        begin
            fg_model = value;
        end
        else if (idx == tgp_pkg::REG_BG_COLOR)
        begin
            bg_model = value;
        end
    endtask

    // A blank glyph leaves nothing expected while the walker is still busy, hence the tail.
    task automatic wait_idle();
        while (char_queue.size() != 0 || in_valid || expected_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY_GAP) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            string_start <= 1'b0;
            start_x      <= '0;
            start_y      <= '0;
            char_code    <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_pixels(string_start, start_x, start_y, char_code);
            end
            if (!in_valid || !in_stall)
            begin
                offer = 1'b0;
                if (char_queue.size() != 0)
                begin
                    next_char = char_queue[0];
                    offer = ($urandom_range(99) >= tx_idle_pct)
                            && (!next_char.drain || expected_pixels.size() == 0);
                end
                if (offer)
                begin
                    next_char    = char_queue.pop_front();
                    in_valid     <= 1'b1;
                    string_start <= next_char.load;
                    start_x      <= next_char.sx;
                    start_y      <= next_char.sy;
                    char_code    <= next_char.code;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_served != hold_request)
        begin
            hold_served = hold_request;
            hold_left   = HOLD_CYCLES;
            out_stall   <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: pixel beat with nothing expected, got x=%0d y=%0d color=%h last=%b",
                         $time, pixel_x, pixel_y, pixel_color, last_pixel);
                mismatches++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (pixel_x !== want.x)
                begin
                    $display("%0t: pixel_x expected %0d got %0d", $time, want.x, pixel_x);
                    mismatches++;
                end
                if (pixel_y !== want.y)
                begin
                    $display("%0t: pixel_y expected %0d got %0d", $time, want.y, pixel_y);
                    mismatches++;
                end
                if (pixel_color !== want.color)
                begin
                    $display("%0t: pixel_color expected %h got %h", $time, want.color,
                             pixel_color);
                    mismatches++;
                end
                if (last_pixel !== want.last)
                begin
                    $display("%0t: last_pixel expected %b got %b", $time, want.last,
                             last_pixel);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        tx_idle_pct = 12;
        rx_idle_pct = 77;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        add_char(1'b1, 8'd0, 8'd0, "A", 1'b0);
        add_char(1'b0, 8'hFF, 8'hFF, "Z", 1'b0);
        add_char(1'b0, 8'd0, 8'd0, 8'd32, 1'b0);
        add_char(1'b0, 8'd0, 8'd0, 8'd33, 1'b0);
        add_char(1'b0, 8'd0, 8'd0, 8'd0, 1'b0);
        add_char(1'b0, 8'd0, 8'd0, 8'd31, 1'b0);
        add_char(1'b0, 8'd0, 8'd0, 8'd91, 1'b0);
        add_char(1'b0, 8'd0, 8'd0, 8'd126, 1'b0);
        add_char(1'b0, 8'd0, 8'd0, 8'd127, 1'b0);
        add_char(1'b0, 8'd0, 8'd0, 8'd255, 1'b0);
        add_char(1'b1, 8'd255, 8'd255, "W", 1'b0);
        add_char(1'b1, 8'd120, 8'd16, "0", 1'b0);
        add_char(1'b0, 8'd0, 8'd0, "9", 1'b0);
        add_char(1'b1, 8'd250, 8'd0, "M", 1'b0);
        add_char(1'b0, 8'd0, 8'd0, "N", 1'b0);
        add_char(1'b1, 8'hAA, 8'h55, "H", 1'b0);
        add_char(1'b1, 8'h55, 8'hAA, "@", 1'b1);
        add_char(1'b1, 8'd116, 8'd248, "X", 1'b0);
        add_char(1'b0, 8'd0, 8'd0, "Y", 1'b0);
        add_char(1'b0, 8'd0, 8'd0, "Z", 1'b0);
        wait_idle();

        write_reg(tgp_pkg::REG_FG_COLOR, 16'h0000);
        write_reg(tgp_pkg::REG_BG_COLOR, 16'hFFFF);
        write_reg(REG_UNUSED_A, 16'($urandom));
        write_reg(REG_UNUSED_B, 16'($urandom));
        queue_text(40);
        wait_idle();

        tx_idle_pct = 77;
        rx_idle_pct = 12;
        shade = 16'($urandom);
        write_reg(tgp_pkg::REG_FG_COLOR, shade);
        write_reg(tgp_pkg::REG_BG_COLOR, shade);
        add_char(1'b1, 8'd10, 8'd20, 8'd32, 1'b0);
        add_char(1'b0, 8'd0, 8'd0, 8'd0, 1'b0);
        add_char(1'b0, 8'd0, 8'd0, 8'd200, 1'b0);
        add_char(1'b0, 8'd0, 8'd0, "K", 1'b1);
        queue_text(40);
        wait_idle();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_reg(tgp_pkg::REG_FG_COLOR, 16'($urandom));
        write_reg(tgp_pkg::REG_BG_COLOR, 16'($urandom));
        hold_request = hold_request + 1;
        queue_text(40);
        wait_idle();

        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
